FILE: design/sprite_slot_table_defines.svh
// ----------------------------------------------------------------------------
// sprite slot table assertion macros
// shared property templates, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SPRITE_SLOT_TABLE_DEFINES_SVH
`define SPRITE_SLOT_TABLE_DEFINES_SVH

// same-cycle implication
`define SST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// types, codes and default sizes for the sprite slot table
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

    // default group sizes
    localparam int SST_ASTEROID_SLOTS     = 5;
    localparam int SST_BULLET_SLOTS       = 4;
    localparam int SST_ENEMY_BULLET_SLOTS = 3;

    // field widths
    localparam int COORD_W = 10;
    localparam int POS_W   = 2 * COORD_W;
    localparam int CMD_W   = 2;
    localparam int GRP_W   = 2;
    localparam int LIMIT_W = 3;
    localparam int SLOT_W  = 3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PLACE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // group codes
    localparam logic [GRP_W-1:0] GRP_ASTEROID = 2'd0;
    localparam logic [GRP_W-1:0] GRP_BULLET   = 2'd1;
    localparam logic [GRP_W-1:0] GRP_ENEMY    = 2'd2;

    typedef logic [POS_W-1:0] pos_t;

    // packed position: y in the upper half, x in the lower half
    function automatic pos_t pack_pos(input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y);
        return {y, x};
    endfunction

endpackage

`default_nettype wire

FILE: design/sprite_slot_table.sv
// ----------------------------------------------------------------------------
// sprite_slot_table
// slot table of sprite positions in three groups with place, move and remove
// ----------------------------------------------------------------------------
// channel  | dir | handshake         | content
// s_*      | in  | s_tvalid/s_tready | tuser: cmd, group; tdata: pos_x, pos_y,
//          |     |                   |   new_x, new_y
// m_*      | out | m_tvalid/m_tready | tuser: hit; tdata: slot
// cfg_*    | in  | cfg_valid/ready   | asteroid_limit
//
// the walk reads the position ram one slot per cycle over the slots searched in
// the item's group and stops at the first free or matching slot; an item with
// nothing to search skips the walk.
// reset clears all valid bits and sets the asteroid limit to 5.
// a new item is accepted while a result still waits on m_*.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sprite_slot_table_defines.svh"

module sprite_slot_table
    import sst_pkg::*;
#(
    parameter int ASTEROID_SLOTS     = SST_ASTEROID_SLOTS,
    parameter int BULLET_SLOTS       = SST_BULLET_SLOTS,
    parameter int ENEMY_BULLET_SLOTS = SST_ENEMY_BULLET_SLOTS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [39:0]        s_tdata,   // pos_x, pos_y, new_x, new_y
    input  wire logic [3:0]         s_tuser,   // cmd, group
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [7:0]         m_tdata,   // slot, zero fill
    output logic      [0:0]         m_tuser,   // hit
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [LIMIT_W-1:0] cfg_data
);

    localparam int TOTAL_SLOTS = ASTEROID_SLOTS + BULLET_SLOTS + ENEMY_BULLET_SLOTS;
    localparam int MAX_A       = ASTEROID_SLOTS > BULLET_SLOTS ? ASTEROID_SLOTS
                                                                : BULLET_SLOTS;
    localparam int MAX_GRP     = MAX_A > ENEMY_BULLET_SLOTS ? MAX_A : ENEMY_BULLET_SLOTS;
    localparam int CNT_W       = $clog2(MAX_GRP + 1);
    localparam int ADDR_W      = $clog2(TOTAL_SLOTS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // input unpacking
    logic [CMD_W-1:0]   in_cmd;
    logic [GRP_W-1:0]   in_group;
    logic [COORD_W-1:0] in_pos_x, in_pos_y, in_new_x, in_new_y;

    assign in_cmd   = s_tuser[1:0];
    assign in_group = s_tuser[3:2];
    assign in_pos_x = s_tdata[9:0];
    assign in_pos_y = s_tdata[19:10];
    assign in_new_x = s_tdata[29:20];
    assign in_new_y = s_tdata[39:30];

    // registers
    logic [1:0]             state_reg, state_next;
    logic [LIMIT_W-1:0]     limit_reg;
    logic [TOTAL_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    pos_t                   oldp_reg, oldp_next;
    pos_t                   newp_reg, newp_next;
    logic [ADDR_W-1:0]      base_reg, base_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   p1_valid_reg, p1_valid_next;
    logic [CNT_W-1:0]       p1_idx_reg, p1_idx_next;
    logic                   res_hit_reg, res_hit_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_hit_reg, out_hit_next;
    logic [SLOT_W-1:0]      out_slot_reg, out_slot_next;

    // ram interface
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    pos_t              ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    pos_t              ram_rdata;

    // scan datapath
    logic              in_fire;
    logic              issue;
    logic [ADDR_W-1:0] cmp_addr;
    logic              entry_valid;
    logic              match;
    logic              last_idx;
    logic [CNT_W-1:0]  grp_count;
    logic [ADDR_W-1:0] grp_base;

    assign in_fire   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_hit_reg;
    assign m_tdata  = {{(8 - SLOT_W){1'b0}}, out_slot_reg};

    // group base and searched count of the incoming item
    always_comb
    begin
        grp_base  = '0;
        grp_count = '0;
        case (in_group)
            GRP_ASTEROID:
            begin
                grp_base  = '0;
                grp_count = (32'(limit_reg) > ASTEROID_SLOTS) ? CNT_W'(ASTEROID_SLOTS)
                                                                : CNT_W'(limit_reg);
            end
            GRP_BULLET:
            begin
                grp_base  = ADDR_W'(ASTEROID_SLOTS);
                grp_count = CNT_W'(BULLET_SLOTS);
            end
            GRP_ENEMY:
            begin
                grp_base  = ADDR_W'(ASTEROID_SLOTS + BULLET_SLOTS);
                grp_count = CNT_W'(ENEMY_BULLET_SLOTS);
            end
            default:
            begin
                grp_base  = '0;
                grp_count = '0;
            end
        endcase
        if (!(in_cmd inside {CMD_PLACE, CMD_MOVE, CMD_REMOVE}))
        begin
            grp_count = '0;
        end
    end

    // compare stage against the entry read on the previous cycle
    assign issue       = (state_reg == ST_SCAN) && (rd_idx_reg < cnt_reg);
    assign ram_raddr   = base_reg + ADDR_W'(rd_idx_reg);
    assign cmp_addr    = base_reg + ADDR_W'(p1_idx_reg);
    assign entry_valid = slot_valid_reg[cmp_addr];
    assign last_idx    = (p1_idx_reg == cnt_reg - CNT_W'(1));

    always_comb
    begin
        if (cmd_reg == CMD_PLACE)
        begin
            match = !entry_valid;
        end
        else
        begin
            match = entry_valid && (ram_rdata == oldp_reg);
        end
    end

    assign ram_we    = (state_reg == ST_SCAN) && p1_valid_reg && match &&
                       (cmd_reg != CMD_REMOVE);
    assign ram_waddr = cmp_addr;
    assign ram_wdata = (cmd_reg == CMD_PLACE) ? oldp_reg : newp_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        slot_valid_next = slot_valid_reg;
        cmd_next        = cmd_reg;
        oldp_next       = oldp_reg;
        newp_next       = newp_reg;
        base_next       = base_reg;
        cnt_next        = cnt_reg;
        rd_idx_next     = rd_idx_reg;
        p1_valid_next   = 1'b0;
        p1_idx_next     = p1_idx_reg;
        res_hit_next    = res_hit_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg;
        out_hit_next    = out_hit_reg;
        out_slot_next   = out_slot_reg;

        // result taken downstream
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next      = in_cmd;
                    oldp_next     = pack_pos(in_pos_x, in_pos_y);
                    newp_next     = pack_pos(in_new_x, in_new_y);
                    base_next     = grp_base;
                    cnt_next      = grp_count;
                    rd_idx_next   = '0;
                    res_hit_next  = 1'b0;
                    res_slot_next = '0;
                    state_next    = (grp_count == '0) ? ST_FIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                p1_valid_next = issue;
                p1_idx_next   = rd_idx_reg;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (p1_valid_reg)
                begin
                    if (match)
                    begin
                        slot_valid_next[cmp_addr] = (cmd_reg != CMD_REMOVE);
                        res_hit_next  = 1'b1;
                        res_slot_next = SLOT_W'(p1_idx_reg);
                        p1_valid_next = 1'b0;
                        state_next    = ST_FIN;
                    end
                    else if (last_idx)
                    begin
                        p1_valid_next = 1'b0;
                        state_next    = ST_FIN;
                    end
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_hit_next   = res_hit_reg;
                    out_slot_next  = res_slot_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_valid_reg <= '0;
            p1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            limit_reg      <= LIMIT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            p1_valid_reg   <= p1_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        oldp_reg     <= oldp_next;
        newp_reg     <= newp_next;
        base_reg     <= base_next;
        cnt_reg      <= cnt_next;
        rd_idx_reg   <= rd_idx_next;
        p1_idx_reg   <= p1_idx_next;
        res_hit_reg  <= res_hit_next;
        res_slot_reg <= res_slot_next;
        out_hit_reg  <= out_hit_next;
        out_slot_reg <= out_slot_next;
    end

    // slot position memory
    sst_ram #(
        .WIDTH (POS_W),
        .DEPTH (TOTAL_SLOTS)
    ) u_pos_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // checks
    `SST_ASSERT_NOW(a_miss_slot_zero, out_valid_reg && !out_hit_reg, out_slot_reg == '0,
        "result without hit carries a nonzero slot")
    `SST_ASSERT_NEXT(a_place_sets_valid,
        ram_we && cmd_reg == CMD_PLACE, slot_valid_reg[$past(cmp_addr)],
        "placed slot not marked valid")
    `SST_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_reg != ST_IDLE,
        "accepted item did not start a search")

endmodule

`default_nettype wire

FILE: design/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 12
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// sprite_slot_table regression bench
// drives place, move, remove and unknown items into the slot table across
// several asteroid limits and checks every hit flag and slot index against
// typed row results or a behavioral table copy, with random stalls on both streams
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import sst_pkg::*;

    // codes the package leaves unnamed
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    localparam logic [GRP_W-1:0] GRP_NONE = 2'd3;

    localparam int AST_SLOTS   = SST_ASTEROID_SLOTS;
    localparam int BUL_SLOTS   = SST_BULLET_SLOTS;
    localparam int ENE_SLOTS   = SST_ENEMY_BULLET_SLOTS;
    localparam int TABLE_SLOTS = AST_SLOTS + BUL_SLOTS + ENE_SLOTS;

    localparam int TOTAL_ITEMS    = 1050;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_RESULT = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int NO_CFG         = -1;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } slot_result_t;

    typedef struct {
        int           item_no;
        slot_result_t res;
    } due_result_t;

    // one directed row; typed rows carry their own result
    typedef struct {
        int                set_limit;
        logic [CMD_W-1:0]  cmd;
        logic [GRP_W-1:0]  grp;
        coord_t            px;
        coord_t            py;
        coord_t            nx;
        coord_t            ny;
        bit                typed;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [39:0]        s_tdata = '0;    // pos_x, pos_y, new_x, new_y
    logic [3:0]         s_tuser = '0;    // cmd, group
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [7:0]         m_tdata;         // slot, zero fill
    logic [0:0]         m_tuser;         // hit
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data = '0;

    // mirrored table state
    bit                 tbl_valid [TABLE_SLOTS];
    pos_t               tbl_pos [TABLE_SLOTS];
    logic [LIMIT_W-1:0] cur_limit = LIMIT_RESET;

    due_result_t due_results[$];
    int          error_count = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          place_hits = 0;
    int          move_hits = 0;
    int          remove_hits = 0;
    int          misses = 0;
    logic [7:0]  limits_seen = '0;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;

    stim_row_t directed_rows [0:24] = '{
        // empty table: nothing to move or remove
        '{NO_CFG, CMD_MOVE,   GRP_ASTEROID, 5, 7, 9, 9, 1, 0, 0},
        '{NO_CFG, CMD_REMOVE, GRP_BULLET,   0, 0, 0, 0, 1, 0, 0},
        // fill the asteroid group, duplicates allowed
        '{NO_CFG, CMD_PLACE,  GRP_ASTEROID, 0, 0, 0, 0, 1, 1, 0},
        '{NO_CFG, CMD_PLACE,  GRP_ASTEROID, 1023, 1023, 0, 0, 1, 1, 1},
        '{NO_CFG, CMD_PLACE,  GRP_ASTEROID, 0, 0, 0, 0, 1, 1, 2},
        '{NO_CFG, CMD_PLACE,  GRP_ASTEROID, 512, 1, 0, 0, 1, 1, 3},
        '{NO_CFG, CMD_PLACE,  GRP_ASTEROID, 1, 512, 0, 0, 1, 1, 4},
        // group full
        '{NO_CFG, CMD_PLACE,  GRP_ASTEROID, 3, 3, 0, 0, 1, 0, 0},
        // lowest matching slot wins
        '{NO_CFG, CMD_REMOVE, GRP_ASTEROID, 0, 0, 0, 0, 0, 0, 0},
        '{NO_CFG, CMD_MOVE,   GRP_ASTEROID, 0, 0, 1023, 0, 0, 0, 0},
        '{NO_CFG, CMD_MOVE,   GRP_ASTEROID, 1023, 1023, 0, 1023, 0, 0, 0},
        // player bullets up to full
        '{NO_CFG, CMD_PLACE,  GRP_BULLET,   0, 1023, 0, 0, 1, 1, 0},
        '{NO_CFG, CMD_PLACE,  GRP_BULLET,   1023, 0, 0, 0, 1, 1, 1},
        '{NO_CFG, CMD_PLACE,  GRP_BULLET,   341, 682, 0, 0, 1, 1, 2},
        '{NO_CFG, CMD_PLACE,  GRP_BULLET,   682, 341, 0, 0, 1, 1, 3},
        '{NO_CFG, CMD_PLACE,  GRP_BULLET,   7, 7, 0, 0, 1, 0, 0},
        // enemy bullets up to full
        '{NO_CFG, CMD_PLACE,  GRP_ENEMY,    1023, 1023, 0, 0, 1, 1, 0},
        '{NO_CFG, CMD_PLACE,  GRP_ENEMY,    0, 0, 0, 0, 1, 1, 1},
        '{NO_CFG, CMD_PLACE,  GRP_ENEMY,    1023, 1023, 0, 0, 1, 1, 2},
        '{NO_CFG, CMD_PLACE,  GRP_ENEMY,    2, 2, 0, 0, 1, 0, 0},
        // unknown command and unknown group change nothing
        '{NO_CFG, CMD_NONE,   GRP_ASTEROID, 1, 512, 0, 0, 1, 0, 0},
        '{NO_CFG, CMD_PLACE,  GRP_NONE,     4, 4, 0, 0, 1, 0, 0},
        // zero limit hides the asteroid group
        '{0,      CMD_PLACE,  GRP_ASTEROID, 9, 9, 0, 0, 1, 0, 0},
        // limit above group size acts as full size; then a smaller limit
        '{7,      CMD_REMOVE, GRP_ASTEROID, 1023, 0, 0, 0, 0, 0, 0},
        '{2,      CMD_PLACE,  GRP_ASTEROID, 100, 200, 0, 0, 0, 0, 0}
    };

    sprite_slot_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // first slot and size of a group as seen by a search
    function automatic void group_span(input logic [GRP_W-1:0] grp, output int base,
                                       output int count);
        base  = 0;
        count = 0;
        case (grp)
            GRP_ASTEROID:
            begin
                count = (cur_limit > AST_SLOTS) ? AST_SLOTS : int'(cur_limit);
            end
            GRP_BULLET:
            begin
                base  = AST_SLOTS;
                count = BUL_SLOTS;
            end
            GRP_ENEMY:
            begin
                base  = AST_SLOTS + BUL_SLOTS;
                count = ENE_SLOTS;
            end
            default:
            begin
                count = 0;
            end
        endcase
    endfunction

    // apply one command to the mirrored table and return its result
    function automatic slot_result_t apply_slot_cmd(input logic [CMD_W-1:0] cmd,
                                                    input logic [GRP_W-1:0] grp,
                                                    input pos_t old_pos,
                                                    input pos_t new_pos);
        slot_result_t r = '0;
        int base;
        int count;
        int k;
        group_span(grp, base, count);
        if (cmd == CMD_NONE)
            count = 0;
        for (int i = 0; i < count && !r.hit; i++)
        begin
            k = base + i;
            if (cmd == CMD_PLACE)
            begin
                if (!tbl_valid[k])
                begin
                    tbl_valid[k] = 1'b1;
                    tbl_pos[k]   = old_pos;
                    r.hit        = 1'b1;
                end
            end
            else if (tbl_valid[k] && tbl_pos[k] == old_pos)
            begin
                if (cmd == CMD_MOVE)
                    tbl_pos[k] = new_pos;
                else
                    tbl_valid[k] = 1'b0;
                r.hit = 1'b1;
            end
            if (r.hit)
                r.slot = i[SLOT_W-1:0];
        end
        return r;
    endfunction

    // coordinate biased toward a few values so positions repeat
    function automatic coord_t pick_coord();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return coord_t'($urandom_range(0, 3));
            default: return coord_t'($urandom_range(0, 1023));
        endcase
    endfunction

    // position of a random live slot of a group, whole asteroid group included
    function automatic bit pick_live(input logic [GRP_W-1:0] grp, output pos_t pos);
        int base;
        int size;
        int live[$];
        base = 0;
        size = 0;
        pos  = '0;
        case (grp)
            GRP_ASTEROID: size = AST_SLOTS;
            GRP_BULLET:
            begin
                base = AST_SLOTS;
                size = BUL_SLOTS;
            end
            GRP_ENEMY:
            begin
                base = AST_SLOTS + BUL_SLOTS;
                size = ENE_SLOTS;
            end
            default: size = 0;
        endcase
        for (int i = base; i < base + size; i++)
            if (tbl_valid[i])
                live.push_back(i);
        if (live.size() == 0)
            return 1'b0;
        pos = tbl_pos[live[$urandom_range(0, live.size() - 1)]];
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int item_no, input int got,
                                   input int want);
        error_count++;
        if (error_count <= 100)
            $display("mismatch: %s on item %0d: got %0d, want %0d", what, item_no, got, want);
    endtask

    // offer one item after a gap, then record what it must return
    task automatic offer_item(input logic [CMD_W-1:0] cmd, input logic [GRP_W-1:0] grp,
                              input coord_t px, input coord_t py, input coord_t nx,
                              input coord_t ny, input bit typed,
                              input slot_result_t typed_res, input int gap);
        slot_result_t r;
        due_result_t  d;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ny, nx, py, px};
        s_tuser  <= {grp, cmd};
        do @(posedge clk); while (!(s_tvalid && s_tready));
        r = apply_slot_cmd(cmd, grp, {py, px}, {ny, nx});
        d.item_no = items_sent;
        d.res     = typed ? typed_res : r;
        due_results.push_back(d);
        items_sent++;
        if (!r.hit)
            misses++;
        else if (cmd == CMD_PLACE)
            place_hits++;
        else if (cmd == CMD_MOVE)
            move_hits++;
        else
            remove_hits++;
    endtask

    // limit write, only once the table has returned every result
    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        cur_limit = value;
        limits_seen[value] = 1'b1;
    endtask

    // stimulus: directed table, then random phases at varying limits
    initial
    begin
        int           plen;
        int           phase;
        int           r;
        logic [CMD_W-1:0] cmd;
        logic [GRP_W-1:0] grp;
        pos_t         live_pos;
        coord_t       px;
        coord_t       py;
        coord_t       nx;
        coord_t       ny;
        logic [LIMIT_W-1:0] lim;

        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_pos[i]   = '0;
        end
        limits_seen[LIMIT_RESET] = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_limit != NO_CFG)
                write_limit(LIMIT_W'(directed_rows[i].set_limit));
            offer_item(directed_rows[i].cmd, directed_rows[i].grp, directed_rows[i].px,
                       directed_rows[i].py, directed_rows[i].nx, directed_rows[i].ny,
                       directed_rows[i].typed, {directed_rows[i].hit, directed_rows[i].slot},
                       $urandom_range(0, 19));
        end

        // random phases
        phase = 0;
        while (items_sent < TOTAL_ITEMS)
        begin
            case (phase)
                0: lim = 3'd7;
                1: lim = 3'd0;
                2: lim = 3'd1;
                3: lim = 3'd5;
                default: lim = LIMIT_W'($urandom_range(0, 7));
            endcase
            write_limit(lim);
            tx_burst = ($urandom_range(0, 3) == 0);
            plen = $urandom_range(40, 120);
            for (int n = 0; n < plen && items_sent < TOTAL_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 38)
                    cmd = CMD_PLACE;
                else if (r < 68)
                    cmd = CMD_MOVE;
                else if (r < 94)
                    cmd = CMD_REMOVE;
                else
                    cmd = CMD_NONE;
                grp = ($urandom_range(0, 99) < 5) ? GRP_NONE : GRP_W'($urandom_range(0, 2));
                if ($urandom_range(0, 1) == 0)
                begin
                    px = pick_coord();
                    py = pick_coord();
                end
                else
                begin
                    px = coord_t'($urandom_range(0, 1023));
                    py = coord_t'($urandom_range(0, 1023));
                end
                // searches mostly aim at a live position
                if (cmd != CMD_PLACE && $urandom_range(0, 3) != 0 && pick_live(grp, live_pos))
                    {py, px} = live_pos;
                nx = ($urandom_range(0, 1) == 0) ? pick_coord() : coord_t'($urandom_range(0, 1023));
                ny = ($urandom_range(0, 1) == 0) ? pick_coord() : coord_t'($urandom_range(0, 1023));
                offer_item(cmd, grp, px, py, nx, ny, 1'b0, '0,
                           tx_burst ? 0 : $urandom_range(0, 19));
            end
            phase++;
        end

        // drain
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d items in %0d phases: %0d place, %0d move, %0d remove hits, %0d misses",
                 items_sent, phase, place_hits, move_hits, remove_hits, misses);
        $display("asteroid limits used (bit per value): %b, one %0d-cycle output hold-off",
                 limits_seen, HOLD_CYCLES);
        if (error_count == 0)
            $display("sprite_slot_table regression: pass");
        else
            $display("sprite_slot_table regression: fail");
        $finish;
    end

    // result side ready, with one long hold-off to back up the table
    initial
    begin
        int stall;
        bit held;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= HOLD_AT_RESULT)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 49) == 0)
                    rx_burst = !rx_burst;
                stall = rx_burst ? 0 : $urandom_range(0, 19);
            end
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    // compare each returned item with the oldest pending one
    always @(posedge clk)
    begin
        due_result_t d;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", -1, m_tuser[0], 0);
            end
            else
            begin
                d = due_results.pop_front();
                if (m_tuser[0] !== d.res.hit)
                    report_mismatch("hit", d.item_no, m_tuser[0], d.res.hit);
                if (m_tdata[SLOT_W-1:0] !== d.res.slot)
                    report_mismatch("slot", d.item_no, m_tdata[SLOT_W-1:0], d.res.slot);
            end
        end
    end

    // watchdog on cycles with no transfer on any channel
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transfer for %0d cycles, %0d results pending",
                 WATCHDOG_LIMIT, due_results.size());
        $display("sprite_slot_table regression: fail");
        $finish;
    end

endmodule
